// ===== rtl/ttdb_pkg.sv =====
// Package for the touch trigger debouncer: config layout, reset values and register indexes.
package ttdb_pkg;

  localparam int unsigned SampleW   = 16;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned ThreshW   = 16;
  localparam int unsigned MarginW   = 8;
  localparam int unsigned ConfirmW  = 8;
  localparam int unsigned IntervalW = 16;
  localparam int unsigned CooldownW = 16;
  localparam int unsigned RunW      = 8;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] RegTouchThreshold = 3'd0;
  localparam logic [CfgIdxW-1:0] RegReleaseMargin  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegConfirmCount   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSampleInterval = 3'd3;
  localparam logic [CfgIdxW-1:0] RegCooldown       = 3'd4;

  // Reset values
  localparam logic [ThreshW-1:0]   RstTouchThreshold = 16'd40;
  localparam logic [MarginW-1:0]   RstReleaseMargin  = 8'd8;
  localparam logic [ConfirmW-1:0]  RstConfirmCount   = 8'd3;
  localparam logic [IntervalW-1:0] RstSampleInterval = 16'd20;
  localparam logic [CooldownW-1:0] RstCooldown       = 16'd1500;

  typedef struct packed {
    logic [ThreshW-1:0]   touch_threshold;
    logic [MarginW-1:0]   release_margin;
    logic [ConfirmW-1:0]  confirm_need;
    logic [IntervalW-1:0] sample_interval_ms;
    logic [CooldownW-1:0] holdoff_ms;
  } cfg_t;

endpackage

// ===== rtl/ttdb_core.sv =====
// Debounce decision logic and the persistent touch state.
module ttdb_core import ttdb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [SampleW-1:0] sample_i,
  input  logic [TimeW-1:0]   time_ms_i,
  input  cfg_t               cfg_i,
  output logic               trigger_o,
  output logic               pressed_o
);

  logic [TimeW-1:0] trigger_time_q, trigger_time_d;
  logic [TimeW-1:0] sample_time_q, sample_time_d;
  logic [RunW-1:0]  below_run_q, below_run_d;
  logic             pressed_q, pressed_d;

  logic [TimeW-1:0]   since_trigger, since_sample;
  logic [ThreshW:0]   release_level;
  logic               in_cooldown, due, touched, released, fire;
  logic [RunW-1:0]    run_inc;

  assign since_trigger = time_ms_i - trigger_time_q;
  assign since_sample  = time_ms_i - sample_time_q;
  assign in_cooldown   = since_trigger < {{(TimeW-CooldownW){1'b0}}, cfg_i.holdoff_ms};
  assign due           = since_sample >= {{(TimeW-IntervalW){1'b0}}, cfg_i.sample_interval_ms};
  assign release_level = {1'b0, cfg_i.touch_threshold}
                       + {{(ThreshW+1-MarginW){1'b0}}, cfg_i.release_margin};
  assign released      = {1'b0, sample_i} > release_level;
  assign touched       = sample_i < cfg_i.touch_threshold;
  // saturate the run length at its top value
  assign run_inc       = (&below_run_q) ? below_run_q : below_run_q + 1'b1;
  assign fire          = !in_cooldown && due && touched && !pressed_q
                       && (run_inc >= cfg_i.confirm_need);

  always_comb begin
    trigger_time_d = trigger_time_q;
    sample_time_d  = sample_time_q;
    below_run_d    = below_run_q;
    pressed_d      = pressed_q;
    if (in_cooldown) begin
      if (released) pressed_d = 1'b0;
    end else if (due) begin
      sample_time_d = time_ms_i;
      if (touched) begin
        below_run_d = run_inc;
        if (fire) begin
          pressed_d      = 1'b1;
          trigger_time_d = time_ms_i;
          below_run_d    = '0;
        end
      end else begin
        below_run_d = '0;
        if (released) pressed_d = 1'b0;
      end
    end
  end

  assign trigger_o = fire;
  assign pressed_o = pressed_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trigger_time_q <= '0;
      sample_time_q  <= '0;
      below_run_q    <= '0;
      pressed_q      <= 1'b0;
    end else if (step_i) begin
      trigger_time_q <= trigger_time_d;
      sample_time_q  <= sample_time_d;
      below_run_q    <= below_run_d;
      pressed_q      <= pressed_d;
    end
  end

endmodule

// ===== rtl/touch_trigger_debouncer.sv =====
// Top level of the capacitive touch trigger debouncer with hysteresis and cooldown.
// An accepted word passes from the input register to the result register behind out_valid_o;
// it waits in the input register while the full result register is stalled.
// Throughput: one word per cycle without result stalls; the decision is one pass of 32-bit
// subtract and compare between the input and result registers, updating the touch state
// in place. Reset (rst_ni low, asynchronous): both stages empty, touch state cleared, config
// registers at their defaults (threshold 40, margin 8, confirm 3, interval 20, cooldown 1500).
module touch_trigger_debouncer import ttdb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // sample channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [SampleW-1:0]  sample_i,
  input  logic [TimeW-1:0]    time_ms_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                trigger_o,
  output logic                pressed_o,
  // configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // ---------------------------------------------------------------------------
  // Configuration registers: always ready, unknown indexes are dropped.
  // ---------------------------------------------------------------------------
  cfg_t cfg_q;
  logic cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.touch_threshold    <= RstTouchThreshold;
      cfg_q.release_margin     <= RstReleaseMargin;
      cfg_q.confirm_need       <= RstConfirmCount;
      cfg_q.sample_interval_ms <= RstSampleInterval;
      cfg_q.holdoff_ms         <= RstCooldown;
    end else if (cfg_we) begin
      case (cfg_index_i)
        RegTouchThreshold: cfg_q.touch_threshold    <= cfg_data_i[ThreshW-1:0];
        RegReleaseMargin:  cfg_q.release_margin     <= cfg_data_i[MarginW-1:0];
        RegConfirmCount:   cfg_q.confirm_need       <= cfg_data_i[ConfirmW-1:0];
        RegSampleInterval: cfg_q.sample_interval_ms <= cfg_data_i[IntervalW-1:0];
        RegCooldown:       cfg_q.holdoff_ms         <= cfg_data_i[CooldownW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: input register feeds the decision pass, result register holds
  // the finished word. Each stage advances when the one after it is free.
  // ---------------------------------------------------------------------------
  logic               s1_valid_q, s1_valid_d;
  logic [SampleW-1:0] s1_sample_q;
  logic [TimeW-1:0]   s1_time_q;
  logic               out_valid_q, out_valid_d;
  logic               out_trigger_q, out_pressed_q;
  logic               out_free, s1_adv, in_acc;
  logic               core_trigger, core_pressed;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) s1_valid_d = 1'b1;
    else if (s1_adv) s1_valid_d = 1'b0;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv) out_valid_d = 1'b1;
    else if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the incoming word.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_sample_q <= sample_i;
      s1_time_q   <= time_ms_i;
    end
  end

  // Decision pass: the touch state updates only when the word moves on.
  ttdb_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (s1_adv),
    .sample_i  (s1_sample_q),
    .time_ms_i (s1_time_q),
    .cfg_i     (cfg_q),
    .trigger_o (core_trigger),
    .pressed_o (core_pressed)
  );

  // Hold the result until the consumer takes it.
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_trigger_q <= core_trigger;
      out_pressed_q <= core_pressed;
    end
  end

  assign out_valid_o = out_valid_q;
  assign trigger_o   = out_trigger_q;
  assign pressed_o   = out_pressed_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // A firing word always reports the flag set.
  a_trigger_sets_pressed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && trigger_o |-> pressed_o)
    else $error("trigger reported without pressed flag");

  // Back-pressure only when both stages hold a word.
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled with a free stage");

  // A word leaving the input stage lands in the result register.
  a_advance_fills_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q)
    else $error("advanced word lost");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the touch trigger debouncer: directed tests, then randomized phases.
module tb_top;
  import ttdb_pkg::*;

  // One row of the directed table. Rows with typed set carry their own result,
  // all other rows are checked against the debounce predictor.
  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic [TimeW-1:0]   stamp;
    logic               typed;
    logic               fire;
    logic               held;
  } touch_row_t;

  typedef struct packed {
    logic fire;
    logic held;
  } touch_result_t;

  typedef enum int {KindTouched, KindBand, KindReleased} sample_kind_e;

  localparam int unsigned RowCount    = 21;
  localparam int unsigned CornerCount = 4;
  localparam int unsigned ChunkCount  = 10;
  localparam int unsigned ChunkWords  = 12;
  localparam int unsigned HoldWords   = 260;
  localparam int unsigned DrainCycles = 8;
  localparam int          SampleMax   = (1 << SampleW) - 1;
  localparam logic [CfgIdxW-1:0] RegPastLast = RegCooldown + 3'd1;
  localparam logic [CfgIdxW-1:0] RegTop      = {CfgIdxW{1'b1}};
  localparam logic [RunW-1:0]    RunMax      = '1;

  // Block ports; every input starts at a known value.
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic [SampleW-1:0]  sample_i    = '0;
  logic [TimeW-1:0]    time_ms_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                trigger_o;
  logic                pressed_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  // Predictor copy of the configuration and the touch state.
  cfg_t             active_cfg;
  logic [TimeW-1:0] last_fire_ms;
  logic [TimeW-1:0] last_count_ms;
  logic [RunW-1:0]  touch_run;
  logic             latched;

  touch_result_t    pending_results[$];
  int unsigned      mismatch_cnt = 0;
  bit               jitter_on    = 1'b1;
  int unsigned      stall_left   = 0;
  logic [TimeW-1:0] now_ms;

  // Directed walk under the reset configuration: threshold 40, release above 48,
  // confirm 3, interval 20, cooldown 1500.
  touch_row_t directed_rows [RowCount] = '{
    '{16'd0,     32'd0,          1'b1, 1'b0, 1'b0}, // reset cooldown window, touched
    '{16'hFFFF,  32'd1499,       1'b1, 1'b0, 1'b0}, // last ms of reset cooldown, max sample
    '{16'd10,    32'd1500,       1'b0, 1'b0, 1'b0}, // cooldown over: first counted touch
    '{16'd10,    32'd1510,       1'b0, 1'b0, 1'b0}, // too early, dropped
    '{16'd10,    32'd1520,       1'b0, 1'b0, 1'b0}, // second counted touch
    '{16'd39,    32'd1540,       1'b0, 1'b0, 1'b0}, // just under threshold: fires
    '{16'd0,     32'd1600,       1'b0, 1'b0, 1'b0}, // cooldown, touch ignored
    '{16'd48,    32'd1700,       1'b0, 1'b0, 1'b0}, // cooldown, at release level: still held
    '{16'd49,    32'd1800,       1'b0, 1'b0, 1'b0}, // cooldown, one above: release
    '{16'd0,     32'd3040,       1'b0, 1'b0, 1'b0}, // cooldown ends exactly here
    '{16'd0,     32'd3060,       1'b0, 1'b0, 1'b0},
    '{16'd0,     32'd3080,       1'b0, 1'b0, 1'b0}, // fires again
    '{16'd0,     32'd4580,       1'b0, 1'b0, 1'b0}, // out of cooldown, still pressed
    '{16'd0,     32'd4600,       1'b0, 1'b0, 1'b0},
    '{16'd0,     32'd4620,       1'b0, 1'b0, 1'b0}, // count reached while pressed: no fire
    '{16'd40,    32'd4640,       1'b0, 1'b0, 1'b0}, // at threshold: clears the run only
    '{16'hFFFF,  32'd4660,       1'b0, 1'b0, 1'b0}, // counted release
    '{16'd0,     32'hFFFF_FFF0,  1'b0, 1'b0, 1'b0}, // close to the time wrap
    '{16'd0,     32'h0000_0004,  1'b0, 1'b0, 1'b0}, // interval met across the wrap
    '{16'd0,     32'h0000_0018,  1'b0, 1'b0, 1'b0}, // fires after the wrap
    '{16'hFFFF,  32'h0000_0019,  1'b0, 1'b0, 1'b0}  // release inside the new cooldown
  };

  // Corner settings: maximum threshold with a release level past the sample range,
  // zero threshold, confirm count zero, confirm count at its top.
  cfg_t corner_settings [CornerCount] = '{
    '{16'hFFFF, 8'hFF, 8'd1,   16'd0,    16'd0},
    '{16'd0,    8'd0,  8'd0,   16'hFFFF, 16'hFFFF},
    '{16'd300,  8'd0,  8'd0,   16'd5,    16'd50},
    '{16'd1200, 8'hFF, 8'hFF,  16'd0,    16'd0}
  };

  touch_trigger_debouncer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .time_ms_i   (time_ms_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .trigger_o   (trigger_o),
    .pressed_o   (pressed_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Advance the debounce state by one sample word and return its result.
  function automatic touch_result_t debounce_step(input logic [SampleW-1:0] s,
                                                  input logic [TimeW-1:0] t);
    touch_result_t    res;
    logic [TimeW-1:0] since_fire;
    logic [TimeW-1:0] since_count;
    logic [ThreshW:0] release_level;
    res.fire      = 1'b0;
    since_fire    = t - last_fire_ms;
    since_count   = t - last_count_ms;
    // 17-bit sum: threshold plus margin never wraps
    release_level = {1'b0, active_cfg.touch_threshold}
                  + {{(ThreshW+1-MarginW){1'b0}}, active_cfg.release_margin};
    if (since_fire < active_cfg.holdoff_ms) begin
      // cooldown: only release is seen, the run and the sample time hold
      if ({1'b0, s} > release_level) latched = 1'b0;
    end else if (since_count >= active_cfg.sample_interval_ms) begin
      last_count_ms = t;
      if (s < active_cfg.touch_threshold) begin
        if (touch_run != RunMax) touch_run = touch_run + 1'b1;
        if (touch_run >= active_cfg.confirm_need && !latched) begin
          latched      = 1'b1;
          last_fire_ms = t;
          touch_run    = '0;
          res.fire     = 1'b1;
        end
      end else begin
        touch_run = '0;
        if ({1'b0, s} > release_level) latched = 1'b0;
      end
    end
    res.held = latched;
    return res;
  endfunction

  // Draw a sample from the touched range, the hysteresis band or the released range.
  function automatic logic [SampleW-1:0] pick_sample(input sample_kind_e kind);
    int thr;
    int rel;
    thr = active_cfg.touch_threshold;
    rel = thr + active_cfg.release_margin;
    if (kind == KindTouched && thr > 0) return SampleW'($urandom_range(0, thr - 1));
    if (kind == KindReleased && rel < SampleMax) begin
      return SampleW'($urandom_range(rel + 1, SampleMax));
    end
    return SampleW'($urandom_range(thr, (rel > SampleMax) ? SampleMax : rel));
  endfunction

  // Mostly one interval apart; now and then too early, or a jump past the cooldown.
  function automatic logic [TimeW-1:0] pick_step();
    int unsigned r;
    int unsigned gap;
    r   = $urandom_range(0, 19);
    gap = active_cfg.sample_interval_ms;
    if (r < 3 && gap > 0) return $urandom_range(0, gap - 1);
    if (r == 3) return active_cfg.holdoff_ms + $urandom_range(0, 50);
    return gap + $urandom_range(0, 3);
  endfunction

  function automatic cfg_t random_settings();
    cfg_t c;
    c.touch_threshold    = ($urandom_range(0, 4) == 0) ? ThreshW'($urandom)
                                                       : ThreshW'($urandom_range(20, 3000));
    c.release_margin     = MarginW'($urandom);
    c.confirm_need       = ConfirmW'($urandom_range(0, 6));
    c.sample_interval_ms = IntervalW'($urandom_range(0, 40));
    c.holdoff_ms         = ($urandom_range(0, 4) == 0) ? '1
                                                       : CooldownW'($urandom_range(0, 400));
    return c;
  endfunction

  // Send one sample word; entered and left at a falling edge. Valid stays high
  // across back-to-back words and drops only for an idle burst.
  task automatic send_word(input logic [SampleW-1:0] s, input logic [TimeW-1:0] t,
                           input logic typed, input touch_result_t typed_res);
    touch_result_t predicted;
    if (jitter_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    time_ms_i  <= t;
    do @(posedge clk_i); while (in_stall_o);
    predicted = debounce_step(s, t);
    pending_results.push_back(typed ? typed_res : predicted);
    @(negedge clk_i);
  endtask

  // Drop valid and hold until every outstanding result has come back.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_results.size() != 0);
  endtask

  // One register write; valid stays high so that writes can follow back to back.
  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegTouchThreshold: active_cfg.touch_threshold    = data[ThreshW-1:0];
      RegReleaseMargin:  active_cfg.release_margin     = data[MarginW-1:0];
      RegConfirmCount:   active_cfg.confirm_need       = data[ConfirmW-1:0];
      RegSampleInterval: active_cfg.sample_interval_ms = data[IntervalW-1:0];
      RegCooldown:       active_cfg.holdoff_ms         = data[CooldownW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // Reprogram all registers once the block is drained. Narrow registers get random
  // upper bits, and a write to an unused index must leave everything alone.
  task automatic apply_settings(input cfg_t c);
    logic [CfgDataW-1:0] data;
    wait_idle();
    cfg_write(CfgIdxW'($urandom_range(RegPastLast, RegTop)), CfgDataW'($urandom));
    cfg_write(RegTouchThreshold, c.touch_threshold);
    data = CfgDataW'($urandom);
    data[MarginW-1:0] = c.release_margin;
    cfg_write(RegReleaseMargin, data);
    data = CfgDataW'($urandom);
    data[ConfirmW-1:0] = c.confirm_need;
    cfg_write(RegConfirmCount, data);
    cfg_write(RegSampleInterval, c.sample_interval_ms);
    cfg_write(RegCooldown, c.holdoff_ms);
    cfg_valid_i <= 1'b0;
  endtask

  // Streaks of one sample kind with random content, plus some noise words
  // with a random sample and a random timestamp.
  task automatic run_chunk();
    sample_kind_e       kind;
    logic [SampleW-1:0] s;
    kind = KindTouched;
    repeat (ChunkWords) begin
      if ($urandom_range(0, 9) == 0) begin
        now_ms = $urandom;
        s      = SampleW'($urandom);
      end else begin
        if ($urandom_range(0, 3) == 0) kind = sample_kind_e'($urandom_range(0, 2));
        now_ms = now_ms + pick_step();
        s      = pick_sample(kind);
      end
      send_word(s, now_ms, 1'b0, '0);
    end
  endtask

  // Receiver side: stall in bursts of random length while jitter is on.
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left  = stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (jitter_on && $urandom_range(0, 5) == 0) begin
      stall_left  = $urandom_range(0, 4);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Compare every accepted result word with the oldest pending one.
  always @(posedge clk_i) begin
    touch_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result word with none pending: trigger %0b pressed %0b",
                 $time, trigger_o, pressed_o);
        mismatch_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (trigger_o !== want.fire) begin
          $display("%0t: trigger expected %0b, got %0b", $time, want.fire, trigger_o);
          mismatch_cnt++;
        end
        if (pressed_o !== want.held) begin
          $display("%0t: pressed expected %0b, got %0b", $time, want.held, pressed_o);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    touch_result_t typed_res;
    cfg_t          hold_cfg;
    active_cfg    = '{RstTouchThreshold, RstReleaseMargin, RstConfirmCount,
                      RstSampleInterval, RstCooldown};
    last_fire_ms  = '0;
    last_count_ms = '0;
    touch_run     = '0;
    latched       = 1'b0;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      typed_res.fire = directed_rows[i].fire;
      typed_res.held = directed_rows[i].held;
      send_word(directed_rows[i].sample, directed_rows[i].stamp, directed_rows[i].typed,
                typed_res);
    end

    // Run saturation: fire on the first touch, then keep touching while pressed so
    // the run sticks at its top. Release inside a stretched cooldown, which leaves
    // the run alone, then one touch must fire at the largest confirm count.
    hold_cfg = '{16'd100, 8'd10, 8'd1, 16'd0, 16'd0};
    apply_settings(hold_cfg);
    now_ms = $urandom;
    repeat (HoldWords) begin
      now_ms = now_ms + 1'b1;
      send_word(pick_sample(KindTouched), now_ms, 1'b0, '0);
    end
    hold_cfg.holdoff_ms = '1;
    apply_settings(hold_cfg);
    now_ms = now_ms + 1'b1;
    send_word(SampleW'(SampleMax), now_ms, 1'b0, '0);
    hold_cfg.confirm_need = RunMax;
    hold_cfg.holdoff_ms   = '0;
    apply_settings(hold_cfg);
    now_ms = now_ms + 1'b1;
    send_word(pick_sample(KindTouched), now_ms, 1'b0, '0);

    // Random phases: corners first, then random settings. One middle phase and
    // the last phase run without any idling on either side.
    for (int c = 0; c < ChunkCount; c++) begin
      jitter_on = (c != 2) && (c != ChunkCount - 1);
      apply_settings((c < CornerCount) ? corner_settings[c] : random_settings());
      now_ms = $urandom;
      run_chunk();
    end

    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("touch_trigger_debouncer regression: pass");
    end else begin
      $display("touch_trigger_debouncer regression: fail");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("touch_trigger_debouncer regression: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ttdb_pkg.sv
rtl/ttdb_core.sv
rtl/touch_trigger_debouncer.sv
sim/tb_top.sv
